// ----- sv/dlc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants for the delayed linear coupling block
// Field widths, action codes, register indexes, the beat types that travel
// along the cell chain, and the ring column helper.
// ----------------------------------------------------------------------------
package dlc_pkg;

    // fixed field widths
    localparam int ACT_W    = 2;
    localparam int NODE_W   = 3;
    localparam int VAR_W    = 1;
    localparam int W_W      = 16;
    localparam int D_W      = 4;
    localparam int X_W      = 16;
    localparam int STEP_W   = 32;
    localparam int SUM_W    = 40;
    localparam int HL_W     = 5;
    localparam int PROD_W   = W_W + X_W;
    // widest ring column and ring length over the parameter range
    localparam int COL_W    = 8;
    localparam int LEN_W    = 9;
    // wrap arithmetic holds up to 17 ring lengths
    localparam int WRAP_W   = 13;

    // defaults for the top level parameters
    localparam int DEF_NODES      = 8;
    localparam int DEF_VARS       = 2;
    localparam int DEF_HIST_DEPTH = 16;

    // reset values of the registers
    localparam logic [HL_W-1:0] HIST_LEN_RST = 5'd16;
    localparam logic            POS_ONLY_RST = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_SAMPLE  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // register indexes
    localparam logic CFG_HIST_LEN = 1'b0;
    localparam logic CFG_POS_ONLY = 1'b1;

    // one sum job moving along the chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [NODE_W-1:0] node;
        logic [VAR_W-1:0]  var_i;
        logic [COL_W-1:0]  col;
    } t_token;

    // weight and delay table write
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] tgt;
        logic [NODE_W-1:0] src;
        logic [W_W-1:0]    weight;
        logic [D_W-1:0]    delay;
    } t_load_wr;

    // history sample write
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] src;
        logic [VAR_W-1:0]  var_i;
        logic [COL_W-1:0]  col;
        logic [X_W-1:0]    sample;
    } t_samp_wr;

    // (s - 1 - d) mod len for s < len, by restoring reduction
    function automatic logic [COL_W-1:0] ring_col(input logic [COL_W-1:0] s,
                                                  input logic [D_W-1:0]   d,
                                                  input logic [LEN_W-1:0] len);
        logic [WRAP_W-1:0] y;
        logic [WRAP_W-1:0] m;
        y = WRAP_W'(s) + (WRAP_W'(len) << 4) - WRAP_W'(d) - WRAP_W'(1);
        for (int b = 4; b >= 0; b--) begin
            m = WRAP_W'(len) << b;
            if (y >= m) begin
                y = y - m;
            end
        end
        return COL_W'(y);
    endfunction

endpackage
`default_nettype wire

// ----- sv/dlc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_in_if: input item channel
// Valid/ready channel carrying one load, sample or compute item per beat.
// ----------------------------------------------------------------------------
interface dlc_in_if;
    logic                             valid;
    logic                             ready;
    logic [dlc_pkg::ACT_W-1:0]        action;
    logic [dlc_pkg::NODE_W-1:0]       target_node;
    logic [dlc_pkg::NODE_W-1:0]       source_node;
    logic [dlc_pkg::VAR_W-1:0]        var_index;
    logic signed [dlc_pkg::W_W-1:0]   weight;
    logic [dlc_pkg::D_W-1:0]          delay;
    logic signed [dlc_pkg::X_W-1:0]   sample;
    logic [dlc_pkg::STEP_W-1:0]       step;

    modport source (output valid, action, target_node, source_node, var_index,
                    weight, delay, sample, step, input ready);
    modport sink   (input valid, action, target_node, source_node, var_index,
                    weight, delay, sample, step, output ready);
endinterface
`default_nettype wire

// ----- sv/dlc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_out_if: result channel
// Valid/ready channel carrying one coupling sum per beat.
// ----------------------------------------------------------------------------
interface dlc_out_if;
    logic                             valid;
    logic                             ready;
    logic [dlc_pkg::NODE_W-1:0]       out_node;
    logic [dlc_pkg::VAR_W-1:0]        out_var;
    logic signed [dlc_pkg::SUM_W-1:0] coupling_sum;
    logic                             last_result;

    modport source (output valid, out_node, out_var, coupling_sum, last_result,
                    input ready);
    modport sink   (input valid, out_node, out_var, coupling_sum, last_result,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/dlc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_cell: one source node of the coupling chain
// Holds the weight and delay column and the sample history of its source
// node, and adds its weighted delayed sample to the partial sum that passes
// through. Two register stages: lookup, then multiply-accumulate.
// ----------------------------------------------------------------------------
module dlc_cell #(
    parameter int NODES      = dlc_pkg::DEF_NODES,
    parameter int VARS       = dlc_pkg::DEF_VARS,
    parameter int HIST_DEPTH = dlc_pkg::DEF_HIST_DEPTH,
    parameter int CELL_ID    = 0
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire  [dlc_pkg::LEN_W-1:0]        i_len,
    input  wire                              i_pos_only,
    input  dlc_pkg::t_load_wr                i_load,
    input  dlc_pkg::t_samp_wr                i_samp,
    input  dlc_pkg::t_token                  i_tok,
    input  wire  signed [dlc_pkg::SUM_W-1:0] i_sum,
    output dlc_pkg::t_token                  o_tok,
    output logic signed [dlc_pkg::SUM_W-1:0] o_sum
);
    import dlc_pkg::*;

    localparam int NIW = $clog2(NODES);
    localparam int VIW = (VARS > 1) ? $clog2(VARS) : 1;
    localparam int HIW = $clog2(HIST_DEPTH);

    logic signed [W_W-1:0] r_wt   [NODES];
    logic [D_W-1:0]        r_dl   [NODES];
    logic [X_W-1:0]        r_hist [VARS][HIST_DEPTH];

    t_token                r_tok_a, r_tok_b;
    logic signed [SUM_W-1:0] r_sum_a, r_sum_b;
    logic signed [W_W-1:0] r_w;
    logic signed [X_W-1:0] r_x;

    logic signed [W_W-1:0] w_w;
    logic [D_W-1:0]        w_d;
    logic [COL_W-1:0]      w_col;
    logic signed [X_W-1:0] w_x;
    logic                  w_use;
    logic signed [PROD_W-1:0] w_prod;

    // table and history writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_wt[i] <= '0;
                r_dl[i] <= '0;
            end
            for (int v = 0; v < VARS; v++) begin
                for (int h = 0; h < HIST_DEPTH; h++) begin
                    r_hist[v][h] <= '0;
                end
            end
        end else begin
            if (i_load.en && int'(i_load.src) == CELL_ID) begin
                r_wt[NIW'(i_load.tgt)] <= i_load.weight;
                r_dl[NIW'(i_load.tgt)] <= i_load.delay;
            end
            if (i_samp.en && int'(i_samp.src) == CELL_ID) begin
                r_hist[VIW'(i_samp.var_i)][HIW'(i_samp.col)] <= i_samp.sample;
            end
        end
    end

    // lookup for the incoming job
    always_comb begin
        w_w   = r_wt[NIW'(i_tok.node)];
        w_d   = r_dl[NIW'(i_tok.node)];
        w_col = ring_col(i_tok.col, w_d, i_len);
        w_x   = r_hist[VIW'(i_tok.var_i)][HIW'(w_col)];
        w_use = !(i_pos_only && (w_w <= 0));
    end

    assign w_prod = r_w * r_x;

    // lookup stage and accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_a <= '0;
            r_tok_b <= '0;
        end else if (i_adv) begin
            r_tok_a <= i_tok;
            r_tok_b <= r_tok_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum_a <= i_sum;
            r_w     <= w_use ? w_w : '0;
            r_x     <= w_x;
            r_sum_b <= r_sum_a + SUM_W'(w_prod);
        end
    end

    assign o_tok = r_tok_b;
    assign o_sum = r_sum_b;

endmodule
`default_nettype wire

// ----- sv/delayed_linear_coupling.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_linear_coupling: delayed linear coupling between network nodes
// Weight and delay tables per node pair, ring sample history per node and
// variable, and one weighted delayed sum per target node and variable.
// ----------------------------------------------------------------------------
// A load item writes its table entry as it is taken. A sample item runs the
// bit-serial step-modulo-length remainder and writes the sample as the
// remainder completes. A compute item runs the same remainder, then issues
// VARS*NODES sum jobs, one a cycle while the result side does not stall, into
// a chain of NODES cells (one per source node, two stages each), and is done
// when the last job leaves the chain. A new item is taken once the previous
// one is done; its last result may still wait in the output register. All
// tables clear at reset.
// ----------------------------------------------------------------------------
module delayed_linear_coupling #(
    parameter int NODES      = dlc_pkg::DEF_NODES,
    parameter int VARS       = dlc_pkg::DEF_VARS,
    parameter int HIST_DEPTH = dlc_pkg::DEF_HIST_DEPTH
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    dlc_in_if.sink                      i_in,
    dlc_out_if.source                   o_out,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_index,
    input  wire  [dlc_pkg::HL_W-1:0]    i_cfg_data
);
    import dlc_pkg::*;

    localparam int NIW   = $clog2(NODES);
    localparam int VIW   = (VARS > 1) ? $clog2(VARS) : 1;
    localparam int CNT_W = $clog2(STEP_W);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MOD   = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                 r_state;
    logic [HL_W-1:0]        r_hist_len;
    logic                   r_pos_only;
    logic [LEN_W-1:0]       w_len;

    logic [STEP_W-1:0]      r_step;
    logic [LEN_W-1:0]       r_rem, n_rem;
    logic [LEN_W:0]         w_trial;
    logic [CNT_W-1:0]       r_cnt;
    logic                   w_mod_done;

    t_action                r_act;
    logic [NODE_W-1:0]      r_src;
    logic [VAR_W-1:0]       r_var;
    logic [X_W-1:0]         r_sample;

    logic [COL_W-1:0]       r_s;
    logic [NIW-1:0]         r_in;
    logic [VIW-1:0]         r_ic;
    logic                   w_last_job;

    logic                   w_accept;
    logic                   w_adv;
    t_load_wr               w_load;
    t_samp_wr               w_samp;

    t_token                  w_tok [NODES+1];
    logic signed [SUM_W-1:0] w_sum [NODES+1];

    logic                    r_out_valid;
    logic [NODE_W-1:0]       r_out_node;
    logic [VAR_W-1:0]        r_out_var;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len <= HIST_LEN_RST;
            r_pos_only <= POS_ONLY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIST_LEN: r_hist_len <= i_cfg_data;
                CFG_POS_ONLY: r_pos_only <= i_cfg_data[0];
                default:      r_hist_len <= r_hist_len;
            endcase
        end
    end

    // effective ring length
    always_comb begin
        if (r_hist_len == '0) begin
            w_len = LEN_W'(1);
        end else if (LEN_W'(r_hist_len) > LEN_W'(HIST_DEPTH)) begin
            w_len = LEN_W'(HIST_DEPTH);
        end else begin
            w_len = LEN_W'(r_hist_len);
        end
    end

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_adv = !r_out_valid || o_out.ready;

    // remainder step, one bit of the step number a cycle
    always_comb begin
        w_trial = {r_rem, r_step[STEP_W-1]};
        if (w_trial >= {1'b0, w_len}) begin
            w_trial = w_trial - {1'b0, w_len};
        end
        n_rem = LEN_W'(w_trial);
    end

    assign w_mod_done = (r_state == ST_MOD) && (r_cnt == CNT_W'(STEP_W - 1));
    assign w_last_job = (int'(r_ic) == VARS - 1) && (int'(r_in) == NODES - 1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_in    <= '0;
            r_ic    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (t_action'(i_in.action) == ACT_SAMPLE ||
                                     t_action'(i_in.action) == ACT_COMPUTE)) begin
                        r_state <= ST_MOD;
                        r_cnt   <= '0;
                    end
                end
                ST_MOD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (w_mod_done) begin
                        if (r_act == ACT_COMPUTE) begin
                            r_state <= ST_ISSUE;
                            r_in    <= '0;
                            r_ic    <= '0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (w_adv) begin
                        if (w_last_job) begin
                            r_state <= ST_DRAIN;
                        end else if (int'(r_in) == NODES - 1) begin
                            r_in <= '0;
                            r_ic <= r_ic + VIW'(1);
                        end else begin
                            r_in <= r_in + NIW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_adv && w_tok[NODES].valid && w_tok[NODES].last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // item capture and remainder datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act    <= t_action'(i_in.action);
            r_src    <= i_in.source_node;
            r_var    <= i_in.var_index;
            r_sample <= i_in.sample;
            r_step   <= i_in.step;
            r_rem    <= '0;
        end else if (r_state == ST_MOD) begin
            r_step <= r_step << 1;
            r_rem  <= n_rem;
            if (w_mod_done) begin
                r_s <= COL_W'(n_rem);
            end
        end
    end

    // table writes
    always_comb begin
        w_load.en     = w_accept && t_action'(i_in.action) == ACT_LOAD &&
                        int'(i_in.target_node) < NODES && int'(i_in.source_node) < NODES;
        w_load.tgt    = i_in.target_node;
        w_load.src    = i_in.source_node;
        w_load.weight = i_in.weight;
        w_load.delay  = i_in.delay;

        w_samp.en     = w_mod_done && r_act == ACT_SAMPLE &&
                        int'(r_src) < NODES && int'(r_var) < VARS;
        w_samp.src    = r_src;
        w_samp.var_i  = r_var;
        w_samp.col    = COL_W'(n_rem);
        w_samp.sample = r_sample;
    end

    // job entering the chain
    always_comb begin
        w_tok[0].valid = (r_state == ST_ISSUE);
        w_tok[0].last  = w_last_job;
        w_tok[0].node  = NODE_W'(r_in);
        w_tok[0].var_i = VAR_W'(r_ic);
        w_tok[0].col   = r_s;
        w_sum[0]       = '0;
    end

    // one cell per source node
    for (genvar g = 0; g < NODES; g++) begin : g_cell
        dlc_cell #(
            .NODES      (NODES),
            .VARS       (VARS),
            .HIST_DEPTH (HIST_DEPTH),
            .CELL_ID    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_len      (w_len),
            .i_pos_only (r_pos_only),
            .i_load     (w_load),
            .i_samp     (w_samp),
            .i_tok      (w_tok[g]),
            .i_sum      (w_sum[g]),
            .o_tok      (w_tok[g+1]),
            .o_sum      (w_sum[g+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[NODES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_node <= w_tok[NODES].node;
            r_out_var  <= w_tok[NODES].var_i;
            r_out_sum  <= w_sum[NODES];
            r_out_last <= w_tok[NODES].last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_node     = r_out_node;
    assign o_out.out_var      = r_out_var;
    assign o_out.coupling_sum = r_out_sum;
    assign o_out.last_result  = r_out_last;

    // checks
    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !w_tok[NODES].valid)
        else $error("job left in chain while idle");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[NODES].valid && w_tok[NODES].last |-> r_state == ST_DRAIN)
        else $error("last sum outside drain");

    a_col_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_samp.en |-> LEN_W'(w_samp.col) < w_len)
        else $error("sample column beyond ring length");

    a_issue_after_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_ISSUE) |-> $past(w_mod_done))
        else $error("issue started without remainder");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: regression bench for delayed_linear_coupling
// Drives load, sample and compute items with random gaps and result stalls.
// A behavioral copy of the tables, the ring history and the registers
// predicts every coupling sum. Each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import dlc_pkg::*;

    localparam int NN      = DEF_NODES;
    localparam int NV      = DEF_VARS;
    localparam int HD      = DEF_HIST_DEPTH;
    localparam int WD_LIM  = 20000;
    localparam int SETTLE  = 200;

    typedef struct {
        logic [NODE_W-1:0]       node;
        logic [VAR_W-1:0]        vi;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_sum_exp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [HL_W-1:0] i_cfg_data;

    dlc_in_if  in_if ();
    dlc_out_if out_if ();

    delayed_linear_coupling dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // behavioral copy of the block state
    logic signed [W_W-1:0] wt_mirror   [NN*NN];
    logic [D_W-1:0]        dly_mirror  [NN*NN];
    logic signed [X_W-1:0] hist_mirror [NV*NN*HD];
    logic [HL_W-1:0]       hist_len_reg;
    logic                  pos_only_reg;

    t_sum_exp sum_q[$];
    int  mismatches;
    int  items_sent;
    int  sums_checked;
    int  idle_cycles;
    bit  calm;

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    function automatic int eff_len();
        if (hist_len_reg == 0) return 1;
        if (hist_len_reg > HD) return HD;
        return int'(hist_len_reg);
    endfunction

    // expected sums of one compute item, variable outer and node inner
    function automatic void predict_couplings(input logic [STEP_W-1:0] stp);
        int len, s, back, col, idx;
        longint acc;
        t_sum_exp e;
        len = eff_len();
        s   = int'(stp % len);
        for (int c = 0; c < NV; c++) begin
            for (int n = 0; n < NN; n++) begin
                acc = 0;
                for (int f = 0; f < NN; f++) begin
                    idx  = n * NN + f;
                    back = (1 + int'(dly_mirror[idx])) % len;
                    col  = (s + len - back) % len;
                    if (pos_only_reg && wt_mirror[idx] <= 0) continue;
                    acc += longint'(wt_mirror[idx])
                         * longint'(hist_mirror[(c * NN + f) * HD + col]);
                end
                e.node = NODE_W'(n);
                e.vi   = VAR_W'(c);
                e.sum  = SUM_W'(acc);
                e.last = (c == NV - 1) && (n == NN - 1);
                sum_q.insert(sum_q.size(), e);
            end
        end
    endfunction

    // apply one accepted item to the mirror
    function automatic void apply_item(input t_action act, input int tgt, input int src,
                                       input int vi, input logic signed [W_W-1:0] w,
                                       input logic [D_W-1:0] d,
                                       input logic signed [X_W-1:0] x,
                                       input logic [STEP_W-1:0] stp);
        case (act)
            ACT_LOAD: begin
                wt_mirror[tgt * NN + src]  = w;
                dly_mirror[tgt * NN + src] = d;
            end
            ACT_SAMPLE: begin
                hist_mirror[(vi * NN + src) * HD + int'(stp % eff_len())] = x;
            end
            ACT_COMPUTE: begin
                predict_couplings(stp);
            end
            default: begin
            end
        endcase
    endfunction

    // send one item, hold it until the beat is taken
    task automatic send_item(input t_action act, input int tgt, input int src,
                             input int vi, input logic signed [W_W-1:0] w,
                             input logic [D_W-1:0] d, input logic signed [X_W-1:0] x,
                             input logic [STEP_W-1:0] stp);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        in_if.valid       = 1'b1;
        in_if.action      = act;
        in_if.target_node = NODE_W'(tgt);
        in_if.source_node = NODE_W'(src);
        in_if.var_index   = VAR_W'(vi);
        in_if.weight      = w;
        in_if.delay       = d;
        in_if.sample      = x;
        in_if.step        = stp;
        do @(posedge i_clk); while (!in_if.ready);
        apply_item(act, tgt, src, vi, w, d, x, stp);
        items_sent++;
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic send_rand(input t_action act);
        send_item(act, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1),
                  W_W'($urandom), D_W'($urandom), X_W'($urandom), $urandom);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(input logic idx, input logic [HL_W-1:0] val);
        while (sum_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_HIST_LEN) hist_len_reg = val;
        else pos_only_reg = val[0];
    endtask

    // result sink stalls
    always @(negedge i_clk) begin
        if (calm) out_if.ready <= 1'b1;
        else if ($urandom_range(0, 9) < 7) out_if.ready <= 1'b1;
        else out_if.ready <= ($urandom_range(0, 15) == 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_sum_exp e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (sum_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sum beat: node %0d var %0d sum %0d",
                             out_if.out_node, out_if.out_var, out_if.coupling_sum);
            end else begin
                e = sum_q.pop_front();
                sums_checked++;
                if (out_if.out_node !== e.node || out_if.out_var !== e.vi ||
                    out_if.coupling_sum !== e.sum || out_if.last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sum mismatch: exp n%0d v%0d %0d last%0d, got n%0d v%0d %0d last%0d",
                                 e.node, e.vi, e.sum, e.last, out_if.out_node,
                                 out_if.out_var, out_if.coupling_sum, out_if.last_result);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIM) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // compute right out of reset: every sum is zero
    task automatic test_reset_state();
        send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, 32'd5);
    endtask

    // field extremes, every action, skipped weights, delay wrap
    task automatic test_directed();
        send_item(ACT_LOAD, 0, 0, 0, 16'sh7FFF, 4'd0, '0, '0);
        send_item(ACT_LOAD, 0, 7, 0, 16'sh8000, 4'd15, '0, '0);
        send_item(ACT_LOAD, 7, 7, 0, 16'sh4000, 4'd15, '0, '0);
        send_item(ACT_LOAD, 7, 0, 0, 16'sh0000, 4'd3, '0, '0);
        send_item(ACT_LOAD, 3, 5, 0, 16'shFFFF, 4'd1, '0, '0);
        send_item(ACT_SAMPLE, 0, 0, 0, '0, '0, 16'sh7FFF, 32'd15);
        send_item(ACT_SAMPLE, 0, 7, 1, '0, '0, 16'sh8000, 32'hFFFF_FFFF);
        send_item(ACT_SAMPLE, 0, 7, 0, '0, '0, 16'sh8000, 32'd0);
        send_item(ACT_SAMPLE, 0, 5, 0, '0, '0, 16'sh0101, 32'd14);
        send_item(ACT_NONE, 7, 7, 1, 16'sh7FFF, 4'd15, 16'sh7FFF, 32'd3);
        send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, 32'd16);
        send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, 32'hFFFF_FFFF);
        write_reg(CFG_POS_ONLY, 5'd0);
        send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, 32'd0);
        send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, 32'd1);
        write_reg(CFG_POS_ONLY, 5'd1);
    endtask

    // ring length: zero, one, over the depth, odd lengths; samples stay put
    task automatic test_hist_len();
        logic [HL_W-1:0] lens[5] = '{5'd0, 5'd1, 5'd31, 5'd5, 5'd16};
        foreach (lens[k]) begin
            write_reg(CFG_HIST_LEN, lens[k]);
            write_reg(CFG_POS_ONLY, HL_W'(k % 2));
            repeat (4) send_rand(ACT_SAMPLE);
            send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0, $urandom);
        end
    endtask

    // random mix, mostly loads and samples feeding computes
    task automatic test_random();
        int r;
        logic [HL_W-1:0] lens[6] = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd9, 5'd16};
        foreach (lens[k]) begin
            write_reg(CFG_HIST_LEN, lens[k]);
            write_reg(CFG_POS_ONLY, HL_W'($urandom_range(0, 1)));
            calm = (k == 2);
            for (int i = 0; i < 38; i++) begin
                r = $urandom_range(0, 99);
                if (r < 35) send_rand(ACT_LOAD);
                else if (r < 75) send_rand(ACT_SAMPLE);
                else if (r < 95) begin
                    if ($urandom_range(0, 3) == 0) send_rand(ACT_COMPUTE);
                    else send_item(ACT_COMPUTE, 0, 0, 0, '0, '0, '0,
                                   $urandom_range(0, 40));
                end else send_rand(ACT_NONE);
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        int w;
        mismatches   = 0;
        items_sent   = 0;
        sums_checked = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_HIST_LEN;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.action = ACT_NONE;
        in_if.target_node = '0;
        in_if.source_node = '0;
        in_if.var_index   = '0;
        in_if.weight      = '0;
        in_if.delay       = '0;
        in_if.sample      = '0;
        in_if.step        = '0;
        out_if.ready      = 1'b0;
        foreach (wt_mirror[k]) begin
            wt_mirror[k]  = '0;
            dly_mirror[k] = '0;
        end
        foreach (hist_mirror[k]) hist_mirror[k] = '0;
        hist_len_reg = HIST_LEN_RST;
        pos_only_reg = POS_ONLY_RST;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed();
        test_hist_len();
        test_random();

        w = 0;
        while (sum_q.size() != 0 && w < WD_LIM) begin
            @(negedge i_clk);
            w++;
        end
        repeat (SETTLE) @(negedge i_clk);

        $display("items sent: %0d, coupling sums checked: %0d, mismatches: %0d",
                 items_sent, sums_checked, mismatches);
        $display("ran ring lengths zero, one, odd, full and above the depth, both weight modes");
        if (mismatches == 0 && sum_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- delayed_linear_coupling.f -----
sv/dlc_pkg.sv
sv/dlc_in_if.sv
sv/dlc_out_if.sv
sv/dlc_cell.sv
sv/delayed_linear_coupling.sv
tb/tb_top.sv
